/* hdl/pas_pkg.sv */
// ----------------------------------------------------------------------------
// pas_pkg
// Shared types and constants for the proximity alert state machine.
// ----------------------------------------------------------------------------
package pas_pkg;

  typedef enum logic [1:0] {
    MODE_INACTIVE = 2'd0,
    MODE_APPROACH = 2'd1,
    MODE_DEPART   = 2'd2,
    MODE_STOPPED  = 2'd3
  } mode_t;

  localparam int CFG_IDX_BITS = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_ALARM_EN       = 3'd0,
    CFG_SIREN_EN       = 3'd1,
    CFG_BEEPER_EN      = 3'd2,
    CFG_ALARM_DIST_M   = 3'd3,
    CFG_DIST_EPS       = 3'd4,
    CFG_CLEAR_DELAY    = 3'd5,
    CFG_SIREN_INTERVAL = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic        alarm_en;
    logic        siren_en;
    logic        beeper_en;
    logic [15:0] alarm_dist_m;
    logic [15:0] dist_eps;
    logic [31:0] clear_delay_ms;
    logic [31:0] siren_gap_ms;
  } cfg_t;

  localparam logic [15:0] RST_ALARM_DIST_M   = 16'd500;
  localparam logic [15:0] RST_DIST_EPS       = 16'd32;
  localparam logic [31:0] RST_CLEAR_DELAY    = 32'd5000;
  localparam logic [31:0] RST_SIREN_INTERVAL = 32'd3000;

  localparam logic [10:0] TONE_OFF     = 11'd0;
  localparam logic [10:0] TONE_LOW     = 11'd600;
  localparam logic [10:0] TONE_HIGH    = 11'd1800;
  localparam logic [31:0] TONE_STEP_MS = 32'd50;
  localparam logic [19:0] SHOWN_MAX    = 20'hFFFFF;

endpackage

/* hdl/pas_if.sv */
// ----------------------------------------------------------------------------
// pas_if
// Channel interfaces: position updates in, alert results out, config writes.
// ----------------------------------------------------------------------------
interface pas_in_if #(
  parameter int INDEX_BITS = 16,
  parameter int DIST_BITS  = 24
);
  logic                  valid;
  logic                  ready;
  logic                  position_valid;
  logic                  nearest_found;
  logic [INDEX_BITS-1:0] nearest_index;
  logic [DIST_BITS-1:0]  nearest_distance;
  logic [31:0]           now_ms;

  modport source (output valid, position_valid, nearest_found, nearest_index,
                  nearest_distance, now_ms, input ready);
  modport sink   (input valid, position_valid, nearest_found, nearest_index,
                  nearest_distance, now_ms, output ready);
endinterface

interface pas_out_if #(
  parameter int INDEX_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            alert_state;
  logic                  restore_area;
  logic                  repaint_hud;
  logic                  show_alert;
  logic [INDEX_BITS-1:0] shown_index;
  logic [19:0]           shown_distance_m;
  logic [10:0]           buzzer_hz;

  modport source (output valid, alert_state, restore_area, repaint_hud, show_alert,
                  shown_index, shown_distance_m, buzzer_hz, input ready);
  modport sink   (input valid, alert_state, restore_area, repaint_hud, show_alert,
                  shown_index, shown_distance_m, buzzer_hz, output ready);
endinterface

interface pas_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/pas_cfg_regs.sv */
// ----------------------------------------------------------------------------
// pas_cfg_regs
// Configuration register file, written one register per transaction.
// ----------------------------------------------------------------------------
module pas_cfg_regs (
  input  logic         clk,
  input  logic         rst_n,
  pas_cfg_if.sink      cfg_ch,
  output pas_pkg::cfg_t cfg
);
  import pas_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_ALARM_EN:       cfg_nxt.alarm_en          = cfg_ch.data[0];
        CFG_SIREN_EN:       cfg_nxt.siren_en          = cfg_ch.data[0];
        CFG_BEEPER_EN:      cfg_nxt.beeper_en         = cfg_ch.data[0];
        CFG_ALARM_DIST_M:   cfg_nxt.alarm_dist_m      = cfg_ch.data[15:0];
        CFG_DIST_EPS:       cfg_nxt.dist_eps          = cfg_ch.data[15:0];
        CFG_CLEAR_DELAY:    cfg_nxt.clear_delay_ms    = cfg_ch.data;
        CFG_SIREN_INTERVAL: cfg_nxt.siren_gap_ms      = cfg_ch.data;
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alarm_en          <= 1'b1;
      cfg_r.siren_en          <= 1'b1;
      cfg_r.beeper_en         <= 1'b1;
      cfg_r.alarm_dist_m      <= RST_ALARM_DIST_M;
      cfg_r.dist_eps          <= RST_DIST_EPS;
      cfg_r.clear_delay_ms    <= RST_CLEAR_DELAY;
      cfg_r.siren_gap_ms      <= RST_SIREN_INTERVAL;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* hdl/pas_core.sv */
// ----------------------------------------------------------------------------
// pas_core
// Alert mode machine, out-of-range clear timer and two-tone siren sequencer.
// ----------------------------------------------------------------------------
module pas_core #(
  parameter int INDEX_BITS = 16,
  parameter int DIST_BITS  = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  pas_pkg::cfg_t         cfg,
  input  logic                  pos_valid,
  input  logic                  found,
  input  logic [INDEX_BITS-1:0] idx,
  input  logic [DIST_BITS-1:0]  cur_dist,
  input  logic [31:0]           now,
  output pas_pkg::mode_t        res_mode,
  output logic                  res_restore,
  output logic                  res_repaint,
  output logic                  res_show,
  output logic [INDEX_BITS-1:0] res_index,
  output logic [19:0]           res_dist_m,
  output logic [10:0]           res_tone
);
  import pas_pkg::*;

  localparam int DW = DIST_BITS + 1;

  mode_t                 mode_r,  mode_nxt, nm;
  logic [INDEX_BITS-1:0] apt_r,   apt_nxt;
  logic                  apv_r,   apv_nxt;
  logic [DIST_BITS-1:0]  prev_r,  prev_nxt;
  logic [31:0]           oors_r,  oors_nxt;
  logic [31:0]           lss_r,   lss_nxt;
  logic                  run_r,   run_nxt;
  logic                  phase_r, phase_nxt;
  logic [31:0]           nstep_r, nstep_nxt;
  logic [10:0]           tone_r,  tone_nxt;

  logic [19:0]           radius;
  logic                  far;
  logic                  approaching;
  logic                  departing;
  logic [31:0]           oors_base;
  logic [31:0]           oor_elapsed;
  logic [31:0]           siren_elapsed;
  logic [31:0]           step_diff;
  logic [DIST_BITS-1:0]  sdist;
  logic [32:0]           rsum;
  logic [28:0]           rnd;

  assign radius        = {cfg.alarm_dist_m, 4'b0000};
  assign far           = 32'(cur_dist) > 32'(radius);
  assign approaching   = (DW'(cur_dist) + DW'(cfg.dist_eps)) < DW'(prev_r);
  assign departing     = DW'(cur_dist) > (DW'(prev_r) + DW'(cfg.dist_eps));
  assign oors_base     = (oors_r == 32'd0) ? now : oors_r;
  assign oor_elapsed   = now - oors_base;
  assign siren_elapsed = now - lss_r;

  always_comb begin
    if (mode_r == MODE_INACTIVE || approaching) begin
      nm = MODE_APPROACH;
    end else if (departing) begin
      nm = MODE_DEPART;
    end else if (32'(cur_dist) <= 32'(radius)) begin
      nm = MODE_STOPPED;
    end else begin
      nm = mode_r;
    end
  end

  always_comb begin
    mode_nxt    = mode_r;
    apt_nxt     = apt_r;
    apv_nxt     = apv_r;
    prev_nxt    = prev_r;
    oors_nxt    = oors_r;
    lss_nxt     = lss_r;
    run_nxt     = run_r;
    phase_nxt   = phase_r;
    nstep_nxt   = nstep_r;
    tone_nxt    = tone_r;
    res_restore = 1'b0;
    res_repaint = 1'b0;
    res_show    = 1'b0;
    res_index   = '0;
    sdist       = '0;
    step_diff   = '0;

    if (!pos_valid || !cfg.alarm_en || !found) begin
      if (!pos_valid || !cfg.alarm_en) begin
        tone_nxt  = TONE_OFF;
        run_nxt   = 1'b0;
        phase_nxt = 1'b0;
        nstep_nxt = '0;
      end
      if (mode_r != MODE_INACTIVE) begin
        mode_nxt    = MODE_INACTIVE;
        apv_nxt     = 1'b0;
        res_restore = 1'b1;
        res_repaint = 1'b1;
      end
      oors_nxt = '0;
    end else if (far) begin
      oors_nxt = oors_base;
      if (oor_elapsed > cfg.clear_delay_ms) begin
        if (mode_r != MODE_INACTIVE) begin
          mode_nxt    = MODE_INACTIVE;
          apv_nxt     = 1'b0;
          res_restore = 1'b1;
          res_repaint = 1'b1;
        end
        oors_nxt = '0;
      end else if (mode_r != MODE_INACTIVE && apv_r) begin
        res_show  = 1'b1;
        res_index = apt_r;
        sdist     = cur_dist;
      end
    end else begin
      oors_nxt = '0;
      if (nm != mode_r) begin
        mode_nxt    = nm;
        apt_nxt     = idx;
        apv_nxt     = 1'b1;
        res_repaint = 1'b1;
        if (nm != MODE_APPROACH) begin
          tone_nxt  = TONE_OFF;
          run_nxt   = 1'b0;
          phase_nxt = 1'b0;
          nstep_nxt = '0;
        end
      end
      res_show  = 1'b1;
      res_index = idx;
      sdist     = cur_dist;
      if (cfg.siren_en && mode_nxt == MODE_APPROACH &&
          siren_elapsed >= cfg.siren_gap_ms) begin
        if (cfg.beeper_en) begin
          run_nxt   = 1'b1;
          phase_nxt = 1'b0;
          nstep_nxt = now + TONE_STEP_MS;
          tone_nxt  = TONE_LOW;
        end
        lss_nxt = now;
      end
      step_diff = now - nstep_nxt;
      if (run_nxt && !step_diff[31]) begin
        if (!phase_nxt) begin
          tone_nxt  = TONE_HIGH;
          phase_nxt = 1'b1;
          nstep_nxt = now + TONE_STEP_MS;
        end else begin
          tone_nxt  = TONE_OFF;
          run_nxt   = 1'b0;
          phase_nxt = 1'b0;
          nstep_nxt = '0;
        end
      end
      prev_nxt = cur_dist;
    end
  end

  // round half up to whole meters, saturate
  assign rsum       = 33'(sdist) + 33'd8;
  assign rnd        = rsum[32:4];
  assign res_dist_m = (rnd > 29'(SHOWN_MAX)) ? SHOWN_MAX : rnd[19:0];
  assign res_mode   = mode_nxt;
  assign res_tone   = tone_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_INACTIVE;
      apt_r   <= '0;
      apv_r   <= 1'b0;
      prev_r  <= '0;
      oors_r  <= '0;
      lss_r   <= '0;
      run_r   <= 1'b0;
      phase_r <= 1'b0;
      nstep_r <= '0;
      tone_r  <= TONE_OFF;
    end else if (step) begin
      mode_r  <= mode_nxt;
      apt_r   <= apt_nxt;
      apv_r   <= apv_nxt;
      prev_r  <= prev_nxt;
      oors_r  <= oors_nxt;
      lss_r   <= lss_nxt;
      run_r   <= run_nxt;
      phase_r <= phase_nxt;
      nstep_r <= nstep_nxt;
      tone_r  <= tone_nxt;
    end
  end

endmodule

/* hdl/proximity_alert_state_machine.sv */
// ----------------------------------------------------------------------------
// proximity_alert_state_machine
// Position update in, alert state / panel / buzzer result out.
//
//   channel   dir  transaction
//   in_ch     in   one position update
//   out_ch    out  one alert result per update
//   cfg_ch    in   one register write (index, data)
//
// An update is registered, evaluated combinationally and its result registered;
// one update per cycle is sustained while out_ch.ready stays high.
// Reset clears the alert, timer and siren state and loads register defaults.
// A stalled result holds its register; the input register still takes one more
// update, then in_ch.ready drops until out_ch.ready returns.
// ----------------------------------------------------------------------------
module proximity_alert_state_machine #(
  parameter int INDEX_BITS = 16,
  parameter int DIST_BITS  = 24
) (
  input  logic      clk,
  input  logic      rst_n,
  pas_in_if.sink    in_ch,
  pas_out_if.source out_ch,
  pas_cfg_if.sink   cfg_ch
);
  import pas_pkg::*;

  cfg_t                  cfg;
  logic                  s0_vld_r, s0_vld_nxt;
  logic                  pv_r;
  logic                  found_r;
  logic [INDEX_BITS-1:0] idx_r;
  logic [DIST_BITS-1:0]  dist_r;
  logic [31:0]           now_r;
  logic                  out_vld_r, out_vld_nxt;
  logic                  adv;
  logic                  fire;

  mode_t                 c_mode;
  logic                  c_restore;
  logic                  c_repaint;
  logic                  c_show;
  logic [INDEX_BITS-1:0] c_index;
  logic [19:0]           c_dist_m;
  logic [10:0]           c_tone;

  logic [1:0]            state_r;
  logic                  restore_r;
  logic                  repaint_r;
  logic                  show_r;
  logic [INDEX_BITS-1:0] sidx_r;
  logic [19:0]           sdist_r;
  logic [10:0]           tone_r;

  pas_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  assign adv          = !out_vld_r || out_ch.ready;
  assign fire         = s0_vld_r && adv;
  assign in_ch.ready  = !s0_vld_r || adv;
  assign s0_vld_nxt   = (in_ch.valid && in_ch.ready) ? 1'b1 : (fire ? 1'b0 : s0_vld_r);
  assign out_vld_nxt  = fire ? 1'b1 : (out_ch.ready ? 1'b0 : out_vld_r);

  pas_core #(
    .INDEX_BITS (INDEX_BITS),
    .DIST_BITS  (DIST_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (fire),
    .cfg         (cfg),
    .pos_valid   (pv_r),
    .found       (found_r),
    .idx         (idx_r),
    .cur_dist    (dist_r),
    .now         (now_r),
    .res_mode    (c_mode),
    .res_restore (c_restore),
    .res_repaint (c_repaint),
    .res_show    (c_show),
    .res_index   (c_index),
    .res_dist_m  (c_dist_m),
    .res_tone    (c_tone)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s0_vld_r  <= s0_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      pv_r    <= in_ch.position_valid;
      found_r <= in_ch.nearest_found;
      idx_r   <= in_ch.nearest_index;
      dist_r  <= in_ch.nearest_distance;
      now_r   <= in_ch.now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      state_r   <= c_mode;
      restore_r <= c_restore;
      repaint_r <= c_repaint;
      show_r    <= c_show;
      sidx_r    <= c_index;
      sdist_r   <= c_dist_m;
      tone_r    <= c_tone;
    end
  end

  assign out_ch.valid            = out_vld_r;
  assign out_ch.alert_state      = state_r;
  assign out_ch.restore_area     = restore_r;
  assign out_ch.repaint_hud      = repaint_r;
  assign out_ch.show_alert       = show_r;
  assign out_ch.shown_index      = sidx_r;
  assign out_ch.shown_distance_m = sdist_r;
  assign out_ch.buzzer_hz        = tone_r;

endmodule

/* hdl/pas_checker.sv */
// ----------------------------------------------------------------------------
// pas_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module pas_checker #(
  parameter int INDEX_BITS = 16
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [1:0]            alert_state,
  input logic                  restore_area,
  input logic                  repaint_hud,
  input logic                  show_alert,
  input logic [INDEX_BITS-1:0] shown_index,
  input logic [19:0]           shown_distance_m,
  input logic [10:0]           buzzer_hz
);
  import pas_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result transaction dropped while stalled");

  a_blank_panel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !show_alert |-> shown_index == '0 && shown_distance_m == 20'd0)
    else $error("panel fields set without panel shown");

  a_tone_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> buzzer_hz == TONE_OFF || buzzer_hz == TONE_LOW ||
                  buzzer_hz == TONE_HIGH)
    else $error("illegal buzzer tone");

  a_restore: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && restore_area |-> repaint_hud && alert_state == MODE_INACTIVE)
    else $error("restore without repaint or inactive state");

endmodule

bind proximity_alert_state_machine pas_checker #(
  .INDEX_BITS (INDEX_BITS)
) u_pas_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .alert_state      (out_ch.alert_state),
  .restore_area     (out_ch.restore_area),
  .repaint_hud      (out_ch.repaint_hud),
  .show_alert       (out_ch.show_alert),
  .shown_index      (out_ch.shown_index),
  .shown_distance_m (out_ch.shown_distance_m),
  .buzzer_hz        (out_ch.buzzer_hz)
);
